// ----- hdl/pwdf_pkg.sv -----
// Package for the pulse-width distance frame transmitter: constants, register indexes, codes.
`default_nettype none
package pwdf_pkg;

	localparam int NUM_SENSORS = 4;

	localparam logic [23:0] GAP_MAX = 24'hFF_FFFF;

	// Register reset values
	localparam logic [23:0] RST_FRAME_GAP   = 24'd100000;
	localparam logic        RST_TX_ENABLE   = 1'b1;
	localparam logic [15:0] RST_SYNC_HIGH   = 16'd1900;
	localparam logic [15:0] RST_SYNC_LOW    = 16'd1000;
	localparam logic [15:0] RST_SHORT_PHASE = 16'd100;
	localparam logic [15:0] RST_LONG_PHASE  = 16'd200;
	localparam logic [7:0]  RST_MAX_TENTHS  = 8'd25;
	localparam logic [7:0]  RST_NO_READING  = 8'd255;

	typedef enum logic [2:0] {
		REG_FRAME_GAP   = 3'd0,
		REG_TX_ENABLE   = 3'd1,
		REG_SYNC_HIGH   = 3'd2,
		REG_SYNC_LOW    = 3'd3,
		REG_SHORT_PHASE = 3'd4,
		REG_LONG_PHASE  = 3'd5,
		REG_MAX_TENTHS  = 3'd6,
		REG_NO_READING  = 3'd7
	} reg_index_t;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_SET   = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		PH_GAP       = 3'd0,
		PH_SYNC_HIGH = 3'd1,
		PH_SYNC_LOW  = 3'd2,
		PH_START     = 3'd3,
		PH_BIT_LOW   = 3'd4,
		PH_BIT_HIGH  = 3'd5
	} phase_t;

	function automatic logic [15:0] at_least_one(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/pulse_width_distance_frame_tx_unit.sv -----
// Top level of the pulse-width distance frame transmitter.
`default_nettype none
// Keeps four distance codes (sensors A..D) and sends them as pulse-width coded
// frames on line_level, one input tick beat per microsecond of line time. Items
// are taken into an input register and then processed into a result register,
// so one item is accepted every cycle and its result is on the outputs once the
// result register has taken it; only out_stall throttles the flow.
// Configuration writes are taken in any cycle (cfg_ready is always high) and
// should only be issued while no item is in flight.
module pulse_width_distance_frame_tx_unit
	import pwdf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [1:0]  sensor_index,
	input  wire logic [7:0]  tenths,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             line_level,
	output logic             frame_busy,
	output logic [7:0]       stored_tenths,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	// configuration
	logic [23:0] frame_gap_q;
	logic        tx_enable_q;
	logic [15:0] sync_high_q, sync_low_q, short_phase_q, long_phase_q;
	logic [7:0]  max_tenths_q, no_reading_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  req_s1;
	logic [1:0]  idx_s1;
	logic [7:0]  tenths_s1;

	// transmitter state
	logic [7:0]  dist_q [NUM_SENSORS];
	logic [31:0] shift_q;
	phase_t      phase_q;
	logic [4:0]  bit_q;
	logic [15:0] timer_q;
	logic [23:0] gap_q;

	logic        adv_s2;
	logic        proc;

	assign cfg_ready = 1'b1;
	assign adv_s2    = !out_valid || !out_stall;
	assign in_stall  = valid_s1 && !adv_s2;
	assign proc      = valid_s1 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_gap_q   <= RST_FRAME_GAP;
			tx_enable_q   <= RST_TX_ENABLE;
			sync_high_q   <= RST_SYNC_HIGH;
			sync_low_q    <= RST_SYNC_LOW;
			short_phase_q <= RST_SHORT_PHASE;
			long_phase_q  <= RST_LONG_PHASE;
			max_tenths_q  <= RST_MAX_TENTHS;
			no_reading_q  <= RST_NO_READING;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_FRAME_GAP:   frame_gap_q   <= cfg_data[23:0];
				REG_TX_ENABLE:   tx_enable_q   <= cfg_data[0];
				REG_SYNC_HIGH:   sync_high_q   <= cfg_data[15:0];
				REG_SYNC_LOW:    sync_low_q    <= cfg_data[15:0];
				REG_SHORT_PHASE: short_phase_q <= cfg_data[15:0];
				REG_LONG_PHASE:  long_phase_q  <= cfg_data[15:0];
				REG_MAX_TENTHS:  max_tenths_q  <= cfg_data[7:0];
				REG_NO_READING:  no_reading_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1    <= req_type;
			idx_s1    <= sensor_index;
			tenths_s1 <= tenths;
		end
	end

	// next-state logic
	logic [7:0]  dist_n [NUM_SENSORS];
	logic [31:0] shift_n;
	phase_t      phase_n;
	logic [4:0]  bit_n;
	logic [15:0] timer_n;
	logic [23:0] gap_n;
	logic        level_n;

	phase_t      cur_ph;
	logic [31:0] cur_shift;
	logic [15:0] cur_timer;
	logic [15:0] ph_len;
	logic        run;
	logic        cur_in_frame;

	always_comb begin
		unique case (phase_q)
			PH_SYNC_HIGH, PH_SYNC_LOW, PH_START, PH_BIT_LOW, PH_BIT_HIGH:
				cur_in_frame = 1'b1;
			default: cur_in_frame = 1'b0;
		endcase
	end

	always_comb begin
		for (int i = 0; i < NUM_SENSORS; i++) begin
			dist_n[i] = dist_q[i];
		end
		shift_n   = shift_q;
		phase_n   = phase_q;
		bit_n     = bit_q;
		timer_n   = timer_q;
		gap_n     = gap_q;
		level_n   = 1'b0;
		run       = 1'b0;
		cur_ph    = phase_q;
		cur_shift = shift_q;
		cur_timer = timer_q;
		ph_len    = 16'd1;

		case (req_t'(req_s1))
			REQ_TICK: begin
				if (!cur_in_frame) begin
					phase_n = PH_GAP;
					if (tx_enable_q && gap_q >= frame_gap_q) begin
						// frame starts: latch codes in order A, D, C, B
						cur_shift = {dist_q[0], dist_q[3], dist_q[2], dist_q[1]};
						cur_ph    = PH_SYNC_HIGH;
						cur_timer = 16'd0;
						bit_n     = 5'd0;
						run       = 1'b1;
					end else if (gap_q != GAP_MAX) begin
						gap_n = gap_q + 24'd1;
					end
				end else if (!tx_enable_q) begin
					// abandoned frame counts as ended on this tick
					phase_n = PH_GAP;
					bit_n   = 5'd0;
					timer_n = 16'd0;
					gap_n   = 24'd1;
				end else begin
					run = 1'b1;
				end
			end
			REQ_SET: begin
				dist_n[idx_s1] = (tenths_s1 <= max_tenths_q) ? tenths_s1 : no_reading_q;
				level_n = cur_in_frame &&
					(phase_q == PH_SYNC_HIGH || phase_q == PH_START ||
					 phase_q == PH_BIT_HIGH);
			end
			REQ_CLEAR: begin
				for (int i = 0; i < NUM_SENSORS; i++) begin
					dist_n[i] = no_reading_q;
				end
				level_n = cur_in_frame &&
					(phase_q == PH_SYNC_HIGH || phase_q == PH_START ||
					 phase_q == PH_BIT_HIGH);
			end
			default: begin
				level_n = cur_in_frame &&
					(phase_q == PH_SYNC_HIGH || phase_q == PH_START ||
					 phase_q == PH_BIT_HIGH);
			end
		endcase

		if (run) begin
			level_n = (cur_ph == PH_SYNC_HIGH || cur_ph == PH_START ||
				cur_ph == PH_BIT_HIGH);
			unique case (cur_ph)
				PH_SYNC_HIGH: ph_len = at_least_one(sync_high_q);
				PH_SYNC_LOW:  ph_len = at_least_one(sync_low_q);
				PH_START:     ph_len = at_least_one(short_phase_q);
				PH_BIT_LOW:   ph_len = at_least_one(cur_shift[31] ? short_phase_q : long_phase_q);
				default:      ph_len = at_least_one(cur_shift[31] ? long_phase_q : short_phase_q);
			endcase
			shift_n = cur_shift;
			phase_n = cur_ph;
			if ({1'b0, cur_timer} + 17'd1 >= {1'b0, ph_len}) begin
				timer_n = 16'd0;
				unique case (cur_ph)
					PH_BIT_HIGH: begin
						shift_n = {cur_shift[30:0], 1'b0};
						if (bit_q == 5'd31) begin
							bit_n   = 5'd0;
							phase_n = PH_GAP;
							gap_n   = 24'd0;
						end else begin
							bit_n   = bit_q + 5'd1;
							phase_n = PH_BIT_LOW;
						end
					end
					PH_START:     phase_n = PH_BIT_LOW;
					PH_SYNC_HIGH: phase_n = PH_SYNC_LOW;
					PH_SYNC_LOW:  phase_n = PH_START;
					default:      phase_n = PH_BIT_HIGH;
				endcase
			end else begin
				timer_n = cur_timer + 16'd1;
			end
		end
	end

	logic busy_n;
	always_comb begin
		unique case (phase_n)
			PH_SYNC_HIGH, PH_SYNC_LOW, PH_START, PH_BIT_LOW, PH_BIT_HIGH: busy_n = 1'b1;
			default: busy_n = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				dist_q[i] <= RST_NO_READING;
			end
			shift_q <= 32'd0;
			phase_q <= PH_GAP;
			bit_q   <= 5'd0;
			timer_q <= 16'd0;
			gap_q   <= RST_FRAME_GAP;
		end else if (proc) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				dist_q[i] <= dist_n[i];
			end
			shift_q <= shift_n;
			phase_q <= phase_n;
			bit_q   <= bit_n;
			timer_q <= timer_n;
			gap_q   <= gap_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s2) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			line_level    <= level_n;
			frame_busy    <= busy_n;
			stored_tenths <= dist_n[idx_s1];
		end
	end

endmodule
`default_nettype wire
